// ===== design/vtpd_pkg.sv =====
`timescale 1ns / 1ps
package vtpd_pkg;

	localparam int NumRegs  = 8;
	localparam int AddrW    = 6;
	localparam int NumStep  = 48;
	localparam int QDepth   = 2;

	localparam logic [63:0] RegReset [NumRegs] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

	typedef logic [NumRegs-1:0][63:0] cfg_regs_t;

	typedef struct packed {
		logic [3:0][31:0] t;
		logic             sat;
	} vtx_t;

	typedef struct packed {
		logic [2:0][47:0] num;
		logic [2:0][31:0] rem;
		logic [2:0]       neg;
		logic [31:0]      den;
		logic [2:0][31:0] orig;
		logic [31:0]      w;
		logic             div;
		logic             sat;
	} dstage_t;

	function automatic dstage_t div_step(dstage_t d);
		dstage_t     r;
		logic [32:0] sh;
		logic        qb;
		r = d;
		for (int k = 0; k < 3; k++) begin
			sh = {d.rem[k], d.num[k][47]};
			qb = 1'b0;
			if (sh >= {1'b0, d.den}) begin
				sh = sh - {1'b0, d.den};
				qb = 1'b1;
			end
			r.rem[k] = sh[31:0];
			r.num[k] = {d.num[k][46:0], qb};
		end
		return r;
	endfunction

endpackage

// ===== design/vtpd_if.sv =====
`timescale 1ns / 1ps
interface vtpd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	logic signed [31:0] in_w;
	modport source (output valid, output in_x, output in_y, output in_z, output in_w,
		input ready);
	modport sink (input valid, input in_x, input in_y, input in_z, input in_w,
		output ready);
endinterface

interface vtpd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_w;
	logic               divided;
	logic               saturated;
	modport source (output valid, output out_x, output out_y, output out_z, output out_w,
		output divided, output saturated, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
		input divided, input saturated, output ready);
endinterface

// ===== design/vertex_transform_perspective_divide.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// in_ch     in   valid/ready   in_x in_y in_z in_w
// out_ch    out  valid/ready   out_x out_y out_z out_w divided saturated
// apb       in   psel/penable  8 x 64-bit matrix registers at 8*i
//
// One vertex per cycle sustained while out_ch.ready stays high. The path holds two
// multiply/sum stages, the two-entry queue, a divider load stage, 48 divider stages
// (one quotient bit each) and the output register.
// arst_n clears all valid bits and loads the identity matrix.
// The back end stalls only on out_ch.ready; the front end stalls when the queue is full.
module vertex_transform_perspective_divide
	import vtpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	vtpd_in_if.sink           in_ch,
	vtpd_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AddrW-1:0]  paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	cfg_regs_t         regs_q;
	logic              fq_valid;
	logic              fq_ready;
	vtx_t              fq_data;
	logic              qb_valid;
	logic              qb_ready;
	vtx_t              qb_data;
	logic [3:0][31:0]  res_t;

	assign pready = 1'b1;
	assign prdata = regs_q[paddr[AddrW-1:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) regs_q[i] <= RegReset[i];
		end else if (psel && penable && pwrite) begin
			regs_q[paddr[AddrW-1:3]] <= pwdata;
		end
	end

	vtpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mat      (regs_q),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_v     ({in_ch.in_w, in_ch.in_z, in_ch.in_y, in_ch.in_x}),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	vtpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	vtpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_data    (qb_data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_t     (res_t),
		.out_div   (out_ch.divided),
		.out_sat   (out_ch.saturated)
	);

	assign out_ch.out_x = res_t[0];
	assign out_ch.out_y = res_t[1];
	assign out_ch.out_z = res_t[2];
	assign out_ch.out_w = res_t[3];

endmodule

// ===== design/vtpd_front.sv =====
`timescale 1ns / 1ps
module vtpd_front
	import vtpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_regs_t   mat,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0][31:0] in_v,
	output logic        q_valid,
	input  logic        q_ready,
	output vtx_t        q_data
);

	logic               en;
	logic               vld_s1;
	logic               vld_s2;
	logic signed [63:0] prod_s1 [4][4];
	vtx_t               res_s2;

	logic signed [65:0] sum    [4];
	logic signed [49:0] shr    [4];
	vtx_t               res_d;

	assign en       = !vld_s2 || q_ready;
	assign in_ready = en;
	assign q_valid  = vld_s2;
	assign q_data   = res_s2;

	always_comb begin
		res_d.sat = 1'b0;
		for (int r = 0; r < 4; r++) begin
			sum[r] = 66'(prod_s1[r][0]) + 66'(prod_s1[r][1])
				+ 66'(prod_s1[r][2]) + 66'(prod_s1[r][3]);
			shr[r] = 50'(sum[r] >>> 16);
			if (shr[r] > 50'sh0_0000_7FFF_FFFF) begin
				res_d.t[r] = 32'h7FFF_FFFF;
				res_d.sat  = 1'b1;
			end else if (shr[r] < -50'sh0_0000_8000_0000) begin
				res_d.t[r] = 32'h8000_0000;
				res_d.sat  = 1'b1;
			end else begin
				res_d.t[r] = shr[r][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= $signed(mat[r*2 + c/2][(c%2)*32 +: 32])
						* $signed(in_v[c]);
				end
			end
			res_s2 <= res_d;
		end
	end

endmodule

// ===== design/vtpd_queue.sv =====
`timescale 1ns / 1ps
module vtpd_queue
	import vtpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  vtx_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output vtx_t pop_data
);

	vtx_t       mem_q [QDepth];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = cnt_q != 2'(QDepth);
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = mem_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

endmodule

// ===== design/vtpd_back.sv =====
`timescale 1ns / 1ps
module vtpd_back
	import vtpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  vtx_t        q_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0][31:0] out_t,
	output logic        out_div,
	output logic        out_sat
);

	logic             en;
	logic [NumStep:0] vld_s;
	dstage_t          st_s [NumStep+1];
	dstage_t          load;
	logic             vld_q;
	logic [3:0][31:0] t_q;
	logic             div_q;
	logic             sat_q;
	logic [3:0][31:0] t_d;
	logic             sat_d;
	logic [31:0]      mag;

	assign en        = !vld_q || out_ready;
	assign q_ready   = en;
	assign out_valid = vld_q;
	assign out_t     = t_q;
	assign out_div   = div_q;
	assign out_sat   = sat_q;

	always_comb begin
		load      = '0;
		load.w    = q_data.t[3];
		load.div  = q_data.t[3] != 32'd0;
		load.sat  = q_data.sat;
		load.den  = q_data.t[3][31] ? 32'(-q_data.t[3]) : q_data.t[3];
		for (int k = 0; k < 3; k++) begin
			mag          = q_data.t[k][31] ? 32'(-q_data.t[k]) : q_data.t[k];
			load.orig[k] = q_data.t[k];
			load.neg[k]  = q_data.t[k][31] ^ q_data.t[3][31];
			load.num[k]  = {mag, 16'd0};
			load.rem[k]  = '0;
		end
	end

	always_comb begin
		sat_d  = st_s[NumStep].sat;
		t_d[3] = st_s[NumStep].w;
		for (int k = 0; k < 3; k++) begin
			if (!st_s[NumStep].div) begin
				t_d[k] = st_s[NumStep].orig[k];
			end else if (st_s[NumStep].neg[k]) begin
				if (st_s[NumStep].num[k] > 48'h0000_8000_0000) begin
					t_d[k] = 32'h8000_0000;
					sat_d  = 1'b1;
				end else begin
					t_d[k] = 32'(-st_s[NumStep].num[k]);
				end
			end else begin
				if (st_s[NumStep].num[k] > 48'h0000_7FFF_FFFF) begin
					t_d[k] = 32'h7FFF_FFFF;
					sat_d  = 1'b1;
				end else begin
					t_d[k] = st_s[NumStep].num[k][31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[NumStep-1:0], q_valid};
			vld_q <= vld_s[NumStep];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= load;
			for (int s = 1; s <= NumStep; s++) begin
				st_s[s] <= div_step(st_s[s-1]);
			end
			t_q   <= t_d;
			div_q <= st_s[NumStep].div;
			sat_q <= sat_d;
		end
	end

endmodule

// ===== design/vtpd_checker.sv =====
`timescale 1ns / 1ps
module vtpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_x,
	input logic [31:0] out_w,
	input logic        divided,
	input logic        pready
);

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_div_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (divided == (out_w != 32'd0)))
		else $error("divided flag disagrees with w");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_w))
		else $error("stalled output changed");

endmodule

bind vertex_transform_perspective_divide vtpd_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_x     (out_ch.out_x),
	.out_w     (out_ch.out_w),
	.divided   (out_ch.divided),
	.pready    (pready)
);
